[src/hac_pkg.sv]
// Package for the heat accumulator with cooldown.
// Holds the request/response payload types and the register and operation codes.
// No dependencies.
package hac_pkg;

   localparam int HEAT_W  = 8;
   localparam int TIMER_W = 16;
   localparam int CSR_W   = 16;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_SHOT  = 2'd1,
      OP_SET   = 2'd2,
      OP_QUERY = 2'd3
   } operation_type;

   typedef enum logic [1:0] {
      CSR_HEAT_LIMIT         = 2'd0,
      CSR_COOL_PERIOD        = 2'd1,
      CSR_INDICATOR_DURATION = 2'd2
   } csr_index_type;

   typedef struct packed {
      operation_type     operation;
      logic [HEAT_W-1:0] new_heat;
   } req_type;

   typedef struct packed {
      logic [HEAT_W-1:0] heat_level;
      logic              overheat_active;
      logic              accepted;
   } rsp_type;

endpackage

[src/hac_stream_if.sv]
// Valid/ready stream channel carrying one payload per request.
// The payload type is set per instance; used with the types of hac_pkg.
interface hac_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/heat_accumulator_cooldown.sv]
// Heat accumulator with cooldown: leaky-bucket heat counter and overheat indicator.
// The response to an accepted request appears on rsp_chan in the cycle after it is accepted.
// Throughput: one request per cycle; a request is taken while the previous
// response waits, as long as that response is taken in the same cycle.
// Reset (synchronous, active high): heat, cool timer and indicator cleared,
// registers back to limit 10, cool period 1000, indicator duration 2000.
module heat_accumulator_cooldown
   import hac_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   hac_stream_if.sink               req_chan,
   hac_stream_if.source             rsp_chan,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   // Configuration registers
   logic [HEAT_W-1:0]  heat_limit_ff;
   logic [TIMER_W-1:0] cool_period_ff;
   logic [TIMER_W-1:0] indicator_duration_ff;

   // Block state
   logic [HEAT_W-1:0]  heat_ff, heat_in;
   logic [TIMER_W-1:0] cool_elapsed_ff, cool_elapsed_in;
   logic [TIMER_W-1:0] indicator_ff, indicator_in;

   // Response register
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Tick intermediates
   logic [TIMER_W-1:0] cool_count;
   logic [HEAT_W-1:0]  heat_tick;
   logic [TIMER_W-1:0] cool_tick;
   logic [HEAT_W-1:0]  heat_plus;

   logic               req_accept;
   operation_type      req_op;
   logic [HEAT_W-1:0]  req_heat;
   logic               ok;

   // The response register frees up when it is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_op         = req_chan.payload.operation;
   assign req_heat       = req_chan.payload.new_heat;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Tick path: advance the cool timer (saturating), leak one unit when it
   // reaches the period, and hold the timer at zero once heat is gone.
   always_comb begin
      cool_count = (cool_elapsed_ff != {TIMER_W{1'b1}}) ?
                   cool_elapsed_ff + TIMER_W'(1) : cool_elapsed_ff;
      heat_tick  = heat_ff;
      cool_tick  = cool_elapsed_ff;
      if (heat_ff != '0) begin
         cool_tick = cool_count;
         if (cool_count >= cool_period_ff) begin
            heat_tick = heat_ff - HEAT_W'(1);
            cool_tick = cool_count - cool_period_ff;
         end
      end
      if (heat_tick == '0) begin
         cool_tick = '0;
      end
   end

   assign heat_plus = heat_ff + HEAT_W'(1);

   // Next state for one request; state holds when nothing is accepted.
   always_comb begin
      heat_in         = heat_ff;
      cool_elapsed_in = cool_elapsed_ff;
      indicator_in    = indicator_ff;
      ok              = 1'b1;
      unique case (req_op)
         OP_TICK: begin
            // Indicator counts down first, then cooling applies.
            indicator_in    = (indicator_ff != '0) ? indicator_ff - TIMER_W'(1)
                                                   : indicator_ff;
            heat_in         = heat_tick;
            cool_elapsed_in = cool_tick;
         end
         OP_SHOT: begin
            // Saturate at the limit; reaching it restarts the indicator.
            if (heat_ff < heat_limit_ff) begin
               heat_in = heat_plus;
               if (heat_plus == heat_limit_ff) begin
                  indicator_in = indicator_duration_ff;
               end
            end
         end
         OP_SET: begin
            // Drop values above the limit; otherwise load and restart cooling.
            if (req_heat > heat_limit_ff) begin
               ok = 1'b0;
            end else begin
               heat_in         = req_heat;
               cool_elapsed_in = '0;
               if (req_heat == heat_limit_ff) begin
                  indicator_in = indicator_duration_ff;
               end
            end
         end
         OP_QUERY: begin
            // Report only.
         end
         default: begin
         end
      endcase
      rsp_data_in.heat_level      = heat_in;
      rsp_data_in.overheat_active = (indicator_in != '0);
      rsp_data_in.accepted        = ok;
   end

   // State and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heat_ff         <= '0;
         cool_elapsed_ff <= '0;
         indicator_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            heat_ff         <= heat_in;
            cool_elapsed_ff <= cool_elapsed_in;
            indicator_ff    <= indicator_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         heat_limit_ff         <= HEAT_W'(10);
         cool_period_ff        <= TIMER_W'(1000);
         indicator_duration_ff <= TIMER_W'(2000);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HEAT_LIMIT:         heat_limit_ff         <= csr_wdata[HEAT_W-1:0];
            CSR_COOL_PERIOD:        cool_period_ff        <= csr_wdata[TIMER_W-1:0];
            CSR_INDICATOR_DURATION: indicator_duration_ff <= csr_wdata[TIMER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Cool timer is held at zero whenever heat is zero.
   a_cool_idle: assert property (@(posedge clock) disable iff (reset)
      (heat_ff == '0) |-> (cool_elapsed_ff == '0))
      else $error("cool timer running with zero heat");

   // Every accepted request yields a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // Only a set request can be rejected.
   a_reject_set_only: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op != OP_SET) |=> rsp_data_ff.accepted)
      else $error("non-set request reported as rejected");

   // A shot below the limit raises heat by exactly one.
   a_shot_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_SHOT && heat_ff < heat_limit_ff)
         |=> (heat_ff == $past(heat_ff) + HEAT_W'(1)))
      else $error("shot did not raise heat by one");

endmodule

[dv/heat_accumulator_cooldown_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for heat_accumulator_cooldown: a clocked driver and monitor
// around the request and response streams, with a heat/cooldown predictor in the monitor.
// Depends on hac_pkg and hac_stream_if from the RTL sources.
module heat_accumulator_cooldown_tb;
   import hac_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 270;
   localparam int PHASE_COUNT = 7;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   hac_stream_if #(.payload_type(req_type)) req_if ();
   hac_stream_if #(.payload_type(rsp_type)) rsp_if ();

   heat_accumulator_cooldown DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predictor copy of the block: register values and heat state.
   logic [HEAT_W-1:0]  limit_cfg;
   logic [TIMER_W-1:0] period_cfg;
   logic [TIMER_W-1:0] glow_cfg;
   logic [HEAT_W-1:0]  heat_now;
   logic [TIMER_W-1:0] cool_count;
   logic [TIMER_W-1:0] glow_left;

   req_type backlog[$];       // requests waiting to be offered on req_if
   rsp_type predicted[$];     // status readings owed by the block, oldest first

   logic req_fired;           // request taken at the last rising edge
   logic steady;              // no idling on either side
   logic hold_requests;       // keep the sender from raising valid
   int   mismatches;
   int   cycle_count;

   always #2 clock = ~clock;

   // Apply one request to the predicted state and return the status it reports.
   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      o.accepted = 1'b1;
      case (r.operation)
         OP_TICK: begin
            // Count the indicator down first, then leak heat.
            if (glow_left != 0) glow_left = glow_left - TIMER_W'(1);
            if (heat_now != 0) begin
               if (cool_count != {TIMER_W{1'b1}}) cool_count = cool_count + TIMER_W'(1);
               if (cool_count >= period_cfg) begin
                  heat_now   = heat_now - HEAT_W'(1);
                  cool_count = cool_count - period_cfg;
               end
            end
            // Hold the cool timer at zero while there is no heat.
            if (heat_now == 0) cool_count = '0;
         end
         OP_SHOT: begin
            // Saturate at the limit; a heat above a lowered limit stays put.
            if (heat_now < limit_cfg) begin
               heat_now = heat_now + HEAT_W'(1);
               if (heat_now == limit_cfg) glow_left = glow_cfg;
            end
         end
         OP_SET: begin
            if (r.new_heat > limit_cfg) begin
               o.accepted = 1'b0;
            end else begin
               heat_now   = r.new_heat;
               cool_count = '0;
               if (r.new_heat == limit_cfg) glow_left = glow_cfg;
            end
         end
         default: ;
      endcase
      o.heat_level      = heat_now;
      o.overheat_active = (glow_left != 0);
      return o;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Driver: change inputs on the falling edge only.
   always @(negedge clock) begin
      logic    next_valid;
      req_type next_item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         next_valid = req_if.valid;
         next_item  = req_if.payload;
         // Drop the request that was taken at the last rising edge.
         if (req_fired) begin
            void'(backlog.pop_front());
            next_valid = 1'b0;
         end
         // Raise valid for the next request unless idling or held off; once raised,
         // hold it with a stable payload until taken.
         if (!next_valid && backlog.size() != 0 && !hold_requests &&
             (steady || $urandom_range(99) >= 16)) begin
            next_valid = 1'b1;
            next_item  = backlog[0];
         end
         req_if.valid   <= next_valid;
         req_if.payload <= next_item;
      end
      rsp_if.ready <= steady || ($urandom_range(99) >= 16);
   end

   // Monitor: sample both handshakes on the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      req_fired <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         // Check the response before predicting this edge's request: the response is
         // registered, so a request taken now cannot be answered at this same edge.
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted.size() == 0) begin
               $error("response with no request outstanding: heat %0d",
                      rsp_if.payload.heat_level);
               mismatches++;
            end else begin
               want = predicted.pop_front();
               check_field("heat_level", int'(want.heat_level),
                           int'(rsp_if.payload.heat_level));
               check_field("overheat_active", int'(want.overheat_active),
                           int'(rsp_if.payload.overheat_active));
               check_field("accepted", int'(want.accepted),
                           int'(rsp_if.payload.accepted));
            end
         end
         if (req_if.valid && req_if.ready)
            predicted.push_back(apply_request(req_if.payload));
      end
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void queue_op(operation_type op, logic [HEAT_W-1:0] nh);
      req_type r;
      r.operation = op;
      r.new_heat  = nh;
      backlog.push_back(r);
   endfunction

   // Write one register while the block is idle, and mirror it in the predictor.
   task automatic program_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_HEAT_LIMIT:         limit_cfg  = value[HEAT_W-1:0];
         CSR_COOL_PERIOD:        period_cfg = value;
         CSR_INDICATOR_DURATION: glow_cfg   = value;
         default: ;
      endcase
   endtask

   // Wait until every request is taken and every response has come back.
   task automatic settle();
      while (backlog.size() != 0 || req_if.valid || predicted.size() != 0)
         @(negedge clock);
   endtask

   // Random traffic built from bursts: tick runs to leak heat and run the indicator
   // down, shot runs of up to the limit plus two, sets around the limit, and noise.
   task automatic queue_random(int count);
      int added;
      int kind;
      int run;
      int nh;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(9);
         case (kind)
            0, 1, 2, 3: run = $urandom_range(40, 1);
            4, 5:       run = $urandom_range(int'(limit_cfg) + 2, 1);
            8:          run = 2;
            9:          run = $urandom_range(4, 1);
            default:    run = 1;
         endcase
         if (run > count - added) run = count - added;
         for (int i = 0; i < run; i++) begin
            case (kind)
               0, 1, 2, 3: queue_op(OP_TICK, HEAT_W'($urandom_range(255)));
               4, 5:       queue_op(OP_SHOT, HEAT_W'($urandom_range(255)));
               6:          queue_op(OP_SET, HEAT_W'($urandom_range(255)));
               7:          queue_op(OP_QUERY, HEAT_W'($urandom_range(255)));
               8: begin
                  // Set just below, at or just above the limit, then shoot.
                  nh = int'(limit_cfg) - 1 + int'($urandom_range(2));
                  if (i == 0) queue_op(OP_SET, nh[HEAT_W-1:0]);
                  else        queue_op(OP_SHOT, HEAT_W'($urandom_range(255)));
               end
               default: queue_op(operation_type'(2'($urandom_range(3))),
                                 HEAT_W'($urandom_range(255)));
            endcase
         end
         added += run;
      end
   endtask

   initial begin
      logic [HEAT_W-1:0]  limit_plan [PHASE_COUNT];
      logic [TIMER_W-1:0] period_plan[PHASE_COUNT];
      logic [TIMER_W-1:0] glow_plan  [PHASE_COUNT];

      limit_plan  = '{1, 255, 5, 12, 40, 200, 8};
      period_plan = '{1, 65535, 3, 7, 20, 2, 65535};
      glow_plan   = '{1, 65535, 4, 30, 100, 9, 1};

      // Drive every input to a known value before the first edge.
      clock          = 1'b0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      req_fired      = 1'b0;
      steady         = 1'b0;
      hold_requests  = 1'b0;
      mismatches     = 0;
      cycle_count    = 0;

      // Reset values of registers and state.
      limit_cfg  = 8'd10;
      period_cfg = 16'd1000;
      glow_cfg   = 16'd2000;
      heat_now   = '0;
      cool_count = '0;
      glow_left  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: small limit, fast leak, short indicator.
      program_csr(CSR_HEAT_LIMIT, 16'd3);
      program_csr(CSR_COOL_PERIOD, 16'd2);
      program_csr(CSR_INDICATOR_DURATION, 16'd3);
      queue_op(OP_QUERY, 8'hFF);      // nothing changes on a query
      queue_op(OP_TICK, 8'h00);       // no heat: cool timer held at zero
      repeat (4) queue_op(OP_SHOT, 8'h00);  // reach the limit, then saturate
      repeat (4) queue_op(OP_TICK, 8'h00);  // indicator runs out while heat leaks
      queue_op(OP_SET, 8'd4);         // just above the limit: rejected
      queue_op(OP_SET, 8'hFF);        // far above: rejected
      queue_op(OP_SET, 8'd3);         // at the limit: indicator restarts
      queue_op(OP_SET, 8'd0);
      queue_op(OP_SET, 8'd2);
      settle();

      // Directed: lower the cool period below the time already elapsed.
      program_csr(CSR_HEAT_LIMIT, 16'd255);
      program_csr(CSR_COOL_PERIOD, 16'd10);
      queue_op(OP_SET, 8'd200);
      repeat (6) queue_op(OP_TICK, 8'h00);
      settle();
      program_csr(CSR_COOL_PERIOD, 16'd2);
      repeat (3) queue_op(OP_TICK, 8'h00);  // leak on each tick until caught up
      settle();

      // Directed: lower the limit below the current heat.
      program_csr(CSR_HEAT_LIMIT, 16'd100);
      queue_op(OP_SHOT, 8'h00);       // above the limit: heat unchanged
      queue_op(OP_SET, 8'd150);       // rejected
      queue_op(OP_SET, 8'd100);       // accepted at the limit
      settle();

      // Random phases, each under its own register setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         program_csr(CSR_HEAT_LIMIT, 16'(limit_plan[p]));
         program_csr(CSR_COOL_PERIOD, period_plan[p]);
         program_csr(CSR_INDICATOR_DURATION, glow_plan[p]);
         steady = (p == 3);
         queue_random(PHASE_ITEMS);
         if (p == 4) begin
            // Halfway through, hold the sender until every response is back.
            while (backlog.size() > PHASE_ITEMS / 2) @(negedge clock);
            hold_requests = 1'b1;
            while (req_if.valid || predicted.size() != 0) @(negedge clock);
            hold_requests = 1'b0;
         end
         settle();
      end
      steady = 1'b0;

      // Let the clock run on to catch any stray response.
      repeat (8) @(negedge clock);
      if (predicted.size() != 0) begin
         $error("%0d responses never arrived", predicted.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
src/hac_pkg.sv
src/hac_stream_if.sv
src/heat_accumulator_cooldown.sv
dv/heat_accumulator_cooldown_tb.sv
